// ===== rtl/cpc_pkg.sv =====
// cpc_pkg: shared types and constants of the cascade pid controller
// holds the register indexes, per-stage configuration struct and controller states
// no dependencies
package cpc_pkg;

    // fixed field widths
    localparam int GAIN_W     = 16;
    localparam int LIM_W      = 15;
    localparam int SP_W       = LIM_W + 1;
    localparam int INT_W      = 32;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 16;

    // register indexes of the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_OUTER_PROP_GAIN    = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_OUTER_INT_GAIN     = 4'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_OUTER_DIFF_GAIN    = 4'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_OUTER_OUTPUT_LIMIT = 4'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_INNER_PROP_GAIN    = 4'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_INNER_INT_GAIN     = 4'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_INNER_DIFF_GAIN    = 4'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_INNER_OUTPUT_LIMIT = 4'd7;

    // reset values
    localparam logic signed [GAIN_W-1:0] PROP_GAIN_RESET = 16'sd256;
    localparam logic signed [GAIN_W-1:0] INT_GAIN_RESET  = 16'sd0;
    localparam logic signed [GAIN_W-1:0] DIFF_GAIN_RESET = 16'sd0;
    localparam logic [LIM_W-1:0]         OUT_LIMIT_RESET = 15'd32767;

    // settings of one pid stage
    typedef struct packed {
        logic signed [GAIN_W-1:0] prop_gain;
        logic signed [GAIN_W-1:0] int_gain;
        logic signed [GAIN_W-1:0] diff_gain;
        logic [LIM_W-1:0]         output_limit;
    } cpc_stage_cfg_t;

    // controller sequence
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_MUL_I,
        ST_INT,
        ST_MUL_P,
        ST_ADD_P,
        ST_MUL_D,
        ST_ADD_D,
        ST_ROUND,
        ST_OUT
    } cpc_state_t;

endpackage

// ===== rtl/cpc_cfg_regs.sv =====
// cpc_cfg_regs: configuration register bank of the cascade pid controller
// decodes the plain write port into the outer and inner stage settings
// depends on cpc_pkg
module cpc_cfg_regs
    import cpc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cpc_stage_cfg_t        outer_cfg,
    output cpc_stage_cfg_t        inner_cfg
);

    cpc_stage_cfg_t outer_cfg_reg, outer_cfg_next;
    cpc_stage_cfg_t inner_cfg_reg, inner_cfg_next;

    // write decode, unknown indexes are dropped
    always_comb begin
        outer_cfg_next = outer_cfg_reg;
        inner_cfg_next = inner_cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                REG_OUTER_PROP_GAIN:    outer_cfg_next.prop_gain    = $signed(cfg_wdata);
                REG_OUTER_INT_GAIN:     outer_cfg_next.int_gain     = $signed(cfg_wdata);
                REG_OUTER_DIFF_GAIN:    outer_cfg_next.diff_gain    = $signed(cfg_wdata);
                REG_OUTER_OUTPUT_LIMIT: outer_cfg_next.output_limit = cfg_wdata[LIM_W-1:0];
                REG_INNER_PROP_GAIN:    inner_cfg_next.prop_gain    = $signed(cfg_wdata);
                REG_INNER_INT_GAIN:     inner_cfg_next.int_gain     = $signed(cfg_wdata);
                REG_INNER_DIFF_GAIN:    inner_cfg_next.diff_gain    = $signed(cfg_wdata);
                REG_INNER_OUTPUT_LIMIT: inner_cfg_next.output_limit = cfg_wdata[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // register bank
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outer_cfg_reg.prop_gain    <= PROP_GAIN_RESET;
            outer_cfg_reg.int_gain     <= INT_GAIN_RESET;
            outer_cfg_reg.diff_gain    <= DIFF_GAIN_RESET;
            outer_cfg_reg.output_limit <= OUT_LIMIT_RESET;
            inner_cfg_reg.prop_gain    <= PROP_GAIN_RESET;
            inner_cfg_reg.int_gain     <= INT_GAIN_RESET;
            inner_cfg_reg.diff_gain    <= DIFF_GAIN_RESET;
            inner_cfg_reg.output_limit <= OUT_LIMIT_RESET;
        end else begin
            outer_cfg_reg <= outer_cfg_next;
            inner_cfg_reg <= inner_cfg_next;
        end
    end

    assign outer_cfg = outer_cfg_reg;
    assign inner_cfg = inner_cfg_reg;

endmodule

// ===== rtl/cpc_serial_mult.sv =====
// cpc_serial_mult: bit-serial signed multiplier, one gain bit per cycle
// shift-right accumulate over the GAIN_W gain bits, the gain sign bit is subtracted
// depends on cpc_pkg
module cpc_serial_mult
    import cpc_pkg::*;
#(
    parameter  int OP_W   = 18,
    localparam int PROD_W = OP_W + GAIN_W + 1
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [GAIN_W-1:0] gain,
    input  logic signed [OP_W-1:0]   operand,
    output logic signed [PROD_W-1:0] product,
    output logic                     done
);

    localparam int CNT_W = $clog2(GAIN_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(GAIN_W - 1);

    logic signed [OP_W:0]   hi_reg, hi_next;
    logic [GAIN_W-1:0]      lo_reg, lo_next;
    logic signed [OP_W-1:0] op_reg, op_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic signed [OP_W:0]   op_ext;
    logic signed [OP_W:0]   part_sum;
    logic                   last_step;

    // one shift-add step
    always_comb begin
        op_ext    = (OP_W+1)'(op_reg);
        last_step = (cnt_reg == LAST_STEP);
        if (!lo_reg[0]) begin
            part_sum = hi_reg;
        end else if (last_step) begin
            part_sum = hi_reg - op_ext;
        end else begin
            part_sum = hi_reg + op_ext;
        end

        hi_next   = hi_reg;
        lo_next   = lo_reg;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            hi_next   = '0;
            lo_next   = gain;
            op_next   = operand;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            hi_next  = {part_sum[OP_W], part_sum[OP_W:1]};
            lo_next  = {part_sum[0], lo_reg[GAIN_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (last_step) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // product shift register
    always_ff @(posedge aclk) begin
        hi_reg <= hi_next;
        lo_reg <= lo_next;
        op_reg <= op_next;
    end

    assign product = {hi_reg, lo_reg};
    assign done    = done_reg;

endmodule

// ===== rtl/cascade_pid_controller.sv =====
// Cascade of two positional pid stages with clamped integrals. Each input transfer
// carries outer measurement, outer target and inner measurement; each result transfer
// carries the drive and the inner setpoint. All six gain products go through one
// bit-serial multiplier that takes one gain bit per cycle; the outer stage runs first,
// then the inner, each forming its integral, proportional and derivative products.
// A new item is accepted while the last result still waits on the master side.
// No clearing pass is needed after reset.
//
// cascade_pid_controller: top level, sequencer and stage datapath
// depends on cpc_pkg, cpc_cfg_regs and cpc_serial_mult
module cascade_pid_controller
    import cpc_pkg::*;
#(
    parameter  int SAMPLE_WIDTH    = 16,
    parameter  int GAIN_FRAC_BITS  = 8,
    parameter  int OUTER_INT_LIMIT = 16384,
    parameter  int INNER_INT_LIMIT = 16384,
    localparam int S_TDATA_W       = ((3 * SAMPLE_WIDTH + 7) / 8) * 8,
    localparam int M_TDATA_W       = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // outer_measured, outer_target, inner_measured
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata    // drive, inner_setpoint
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int ERR_W  = ((SW > SP_W) ? SW : SP_W) + 1;
    localparam int DIFF_W = ERR_W + 1;
    localparam int ACC_W  = DIFF_W + GAIN_W + 1;

    localparam logic signed [ACC_W-1:0] HALF       = ACC_W'((1 << GAIN_FRAC_BITS) >> 1);
    localparam logic signed [ACC_W-1:0] OUTER_ILIM = ACC_W'(OUTER_INT_LIMIT << GAIN_FRAC_BITS);
    localparam logic signed [ACC_W-1:0] INNER_ILIM = ACC_W'(INNER_INT_LIMIT << GAIN_FRAC_BITS);

    cpc_stage_cfg_t outer_cfg, inner_cfg, cur_cfg;

    cpc_state_t state_reg, state_next;
    logic       stage_reg, stage_next;

    logic signed [SW-1:0]     om_reg, om_next;
    logic signed [SW-1:0]     ot_reg, ot_next;
    logic signed [SW-1:0]     im_reg, im_next;
    logic signed [ERR_W-1:0]  err_reg, err_next;
    logic signed [DIFF_W-1:0] diff_reg, diff_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [ERR_W-1:0]  last_err_reg [2];
    logic signed [ERR_W-1:0]  last_err_next;
    logic signed [INT_W-1:0]  integral_reg [2];
    logic signed [INT_W-1:0]  integral_next;
    logic                     last_err_we, integral_we;
    logic signed [SP_W-1:0]   sp_reg, sp_next;
    logic [SW-1:0]            sp_out_reg, sp_out_next;
    logic [SW-1:0]            drive_reg, drive_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]     m_tdata_reg, m_tdata_next;

    logic signed [ERR_W-1:0]  meas, target, err_calc;
    logic signed [DIFF_W-1:0] diff_calc;
    logic signed [ACC_W-1:0]  ilim, int_sum, int_clamped;
    logic signed [ACC_W-1:0]  rounded, out_lim, out_clamped;

    logic                     mul_start, mul_done;
    logic signed [GAIN_W-1:0] mul_gain;
    logic signed [DIFF_W-1:0] mul_op;
    logic signed [ACC_W-1:0]  mul_product;

    cpc_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .outer_cfg (outer_cfg),
        .inner_cfg (inner_cfg)
    );

    cpc_serial_mult #(
        .OP_W (DIFF_W)
    ) u_mult (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .gain    (mul_gain),
        .operand (mul_op),
        .product (mul_product),
        .done    (mul_done)
    );

    // stage datapath
    always_comb begin
        cur_cfg   = stage_reg ? inner_cfg : outer_cfg;
        meas      = stage_reg ? ERR_W'(im_reg) : ERR_W'(om_reg);
        target    = stage_reg ? ERR_W'(sp_reg) : ERR_W'(ot_reg);
        err_calc  = target - meas;
        diff_calc = DIFF_W'(err_calc) - DIFF_W'(last_err_reg[stage_reg]);

        // integral update with clamp
        ilim    = stage_reg ? INNER_ILIM : OUTER_ILIM;
        int_sum = ACC_W'(integral_reg[stage_reg]) + mul_product;
        if (int_sum > ilim) begin
            int_clamped = ilim;
        end else if (int_sum < -ilim) begin
            int_clamped = -ilim;
        end else begin
            int_clamped = int_sum;
        end

        // round half up, then output clamp
        rounded = (acc_reg + HALF) >>> GAIN_FRAC_BITS;
        out_lim = ACC_W'(cur_cfg.output_limit);
        if (rounded > out_lim) begin
            out_clamped = out_lim;
        end else if (rounded < -out_lim) begin
            out_clamped = -out_lim;
        end else begin
            out_clamped = rounded;
        end
    end

    // multiplier operand select
    always_comb begin
        case (state_reg)
            ST_ERR: begin
                mul_gain = cur_cfg.int_gain;
                mul_op   = DIFF_W'(err_calc);
            end
            ST_INT: begin
                mul_gain = cur_cfg.prop_gain;
                mul_op   = DIFF_W'(err_reg);
            end
            default: begin
                mul_gain = cur_cfg.diff_gain;
                mul_op   = diff_reg;
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        stage_next    = stage_reg;
        om_next       = om_reg;
        ot_next       = ot_reg;
        im_next       = im_reg;
        err_next      = err_reg;
        diff_next     = diff_reg;
        acc_next      = acc_reg;
        sp_next       = sp_reg;
        sp_out_next   = sp_out_reg;
        drive_next    = drive_reg;
        last_err_next = err_reg;
        integral_next = int_clamped[INT_W-1:0];
        last_err_we   = 1'b0;
        integral_we   = 1'b0;
        mul_start     = 1'b0;
        s_tready      = 1'b0;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        // result register drains independently of the sequence
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                stage_next = 1'b0;
                if (s_tvalid) begin
                    om_next    = s_tdata[SW-1:0];
                    ot_next    = s_tdata[2*SW-1:SW];
                    im_next    = s_tdata[3*SW-1:2*SW];
                    state_next = ST_ERR;
                end
            end
            ST_ERR: begin
                err_next   = err_calc;
                diff_next  = diff_calc;
                mul_start  = 1'b1;
                state_next = ST_MUL_I;
            end
            ST_MUL_I: begin
                if (mul_done) begin
                    state_next = ST_INT;
                end
            end
            ST_INT: begin
                integral_we = 1'b1;
                acc_next    = int_clamped;
                mul_start   = 1'b1;
                state_next  = ST_MUL_P;
            end
            ST_MUL_P: begin
                if (mul_done) begin
                    state_next = ST_ADD_P;
                end
            end
            ST_ADD_P: begin
                acc_next   = acc_reg + mul_product;
                mul_start  = 1'b1;
                state_next = ST_MUL_D;
            end
            ST_MUL_D: begin
                if (mul_done) begin
                    state_next = ST_ADD_D;
                end
            end
            ST_ADD_D: begin
                acc_next    = acc_reg + mul_product;
                last_err_we = 1'b1;
                state_next  = ST_ROUND;
            end
            ST_ROUND: begin
                if (!stage_reg) begin
                    sp_next     = out_clamped[SP_W-1:0];
                    sp_out_next = out_clamped[SW-1:0];
                    stage_next  = 1'b1;
                    state_next  = ST_ERR;
                end else begin
                    drive_next = out_clamped[SW-1:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_TDATA_W'({sp_out_reg, drive_reg});
                    stage_next    = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and loop state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            stage_reg       <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            last_err_reg[0] <= '0;
            last_err_reg[1] <= '0;
            integral_reg[0] <= '0;
            integral_reg[1] <= '0;
        end else begin
            state_reg    <= state_next;
            stage_reg    <= stage_next;
            m_tvalid_reg <= m_tvalid_next;
            if (last_err_we) begin
                last_err_reg[stage_reg] <= last_err_next;
            end
            if (integral_we) begin
                integral_reg[stage_reg] <= integral_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        om_reg      <= om_next;
        ot_reg      <= ot_next;
        im_reg      <= im_next;
        err_reg     <= err_next;
        diff_reg    <= diff_next;
        acc_reg     <= acc_next;
        sp_reg      <= sp_next;
        sp_out_reg  <= sp_out_next;
        drive_reg   <= drive_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== tb/cascade_pid_controller_tb.sv =====
// cascade_pid_controller_tb: self-checking testbench of the cascade pid controller
// predicts drive and inner setpoint per input transfer and checks every result transfer
// depends on cpc_pkg and cascade_pid_controller
module cascade_pid_controller_tb;
    import cpc_pkg::*;

    localparam int SAMPLE_W  = 16;
    localparam int FRAC      = 8;
    localparam int OUTER_ILIM = 16384;
    localparam int INNER_ILIM = 16384;
    localparam int S_DATA_W  = 48;
    localparam int M_DATA_W  = 32;
    localparam int OUTER     = 0;
    localparam int INNER     = 1;
    localparam int RAND_PHASES     = 11;
    localparam int ITEMS_PER_PHASE = 170;
    localparam int DRAIN_CYCLES    = 120;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // one pid stage: settings and running state
    typedef struct {
        longint kp;
        longint ki;
        longint kd;
        longint lim;
        longint ilim;
        longint last_err;
        longint integ;
    } pid_stage_t;

    // result fields, drive in the low half
    typedef struct packed {
        sample_t setpoint;
        sample_t drive;
    } cascade_out_t;

    // predictor of both stages plus the store of expected results
    class pid_cascade_predictor;
        pid_stage_t   stg[2];
        cascade_out_t drive_q[$];
        int           errors;

        function new();
            for (int k = 0; k < 2; k++) begin
                stg[k].kp       = longint'(PROP_GAIN_RESET);
                stg[k].ki       = longint'(INT_GAIN_RESET);
                stg[k].kd       = longint'(DIFF_GAIN_RESET);
                stg[k].lim      = longint'(OUT_LIMIT_RESET);
                stg[k].last_err = 0;
                stg[k].integ    = 0;
            end
            stg[OUTER].ilim = OUTER_ILIM;
            stg[INNER].ilim = INNER_ILIM;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_OUTER_PROP_GAIN:    stg[OUTER].kp  = longint'($signed(val));
                REG_OUTER_INT_GAIN:     stg[OUTER].ki  = longint'($signed(val));
                REG_OUTER_DIFF_GAIN:    stg[OUTER].kd  = longint'($signed(val));
                REG_OUTER_OUTPUT_LIMIT: stg[OUTER].lim = longint'(val[LIM_W-1:0]);
                REG_INNER_PROP_GAIN:    stg[INNER].kp  = longint'($signed(val));
                REG_INNER_INT_GAIN:     stg[INNER].ki  = longint'($signed(val));
                REG_INNER_DIFF_GAIN:    stg[INNER].kd  = longint'($signed(val));
                REG_INNER_OUTPUT_LIMIT: stg[INNER].lim = longint'(val[LIM_W-1:0]);
                default: ;
            endcase
        endfunction

        function longint clamp_sym(longint v, longint lim);
            if (v > lim)
                return lim;
            if (v < -lim)
                return -lim;
            return v;
        endfunction

        function longint run_stage(int k, longint meas, longint tgt);
            longint err;
            longint sum;
            err = tgt - meas;
            stg[k].integ = clamp_sym(stg[k].integ + stg[k].ki * err, stg[k].ilim <<< FRAC);
            sum = stg[k].kp * err + stg[k].integ + stg[k].kd * (err - stg[k].last_err);
            stg[k].last_err = err;
            // round half up, then symmetric output clamp
            return clamp_sym((sum + (64'sd1 <<< (FRAC - 1))) >>> FRAC, stg[k].lim);
        endfunction

        function void note_sample(sample_t om, sample_t ot, sample_t im);
            longint       sp;
            longint       dr;
            cascade_out_t r;
            sp = run_stage(OUTER, om, ot);
            dr = run_stage(INNER, im, sp);
            r.drive    = dr[SAMPLE_W-1:0];
            r.setpoint = sp[SAMPLE_W-1:0];
            drive_q.push_back(r);
        endfunction

        function void check_output(cascade_out_t got);
            cascade_out_t exp_r;
            if (drive_q.size() == 0) begin
                errors++;
                $display("%0t unexpected result: expected none actual drive %0d setpoint %0d",
                         $time, got.drive, got.setpoint);
                return;
            end
            exp_r = drive_q.pop_front();
            if (got.drive !== exp_r.drive) begin
                errors++;
                $display("%0t drive mismatch: expected %0d actual %0d",
                         $time, exp_r.drive, got.drive);
            end
            if (got.setpoint !== exp_r.setpoint) begin
                errors++;
                $display("%0t inner setpoint mismatch: expected %0d actual %0d",
                         $time, exp_r.setpoint, got.setpoint);
            end
        endfunction

        function int pending();
            return drive_q.size();
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;    // outer_measured, outer_target, inner_measured
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;    // drive, inner_setpoint

    pid_cascade_predictor model;
    int gap_pct;
    int stall_pct;

    cascade_pid_controller #(
        .SAMPLE_WIDTH    (SAMPLE_W),
        .GAIN_FRAC_BITS  (FRAC),
        .OUTER_INT_LIMIT (OUTER_ILIM),
        .INNER_INT_LIMIT (INNER_ILIM)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result side: ready with random stall bursts
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // check every result transfer
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            model.check_output(cascade_out_t'(m_tdata[2*SAMPLE_W-1:0]));
    end

    // one register write, enable left high for back-to-back writes
    task automatic cfg_write(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        model.write_reg(idx, val);
        @(negedge aclk);
    endtask

    // one input transfer, with an optional gap in front
    task automatic send_sample(sample_t om, sample_t ot, sample_t im);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {im, ot, om};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        model.note_sample(om, ot, im);
        @(negedge aclk);
    endtask

    // block is idle once every expected result is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (model.pending() != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        case ($urandom_range(0, 7))
            0, 1:    return CFG_DATA_W'($urandom());
            2:       return '0;
            3:       return 16'h7FFF;
            4:       return 16'h8000;
            default: return CFG_DATA_W'(int'($urandom_range(0, 1536)) - 768);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_limit();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            3:       return CFG_DATA_W'($urandom_range(0, 300));
            default: return CFG_DATA_W'($urandom());
        endcase
    endfunction

    // every register gets a fresh value, now and then a write past the last index
    task automatic random_config();
        logic [CFG_ADDR_W-1:0] idx;
        for (int i = 0; i <= int'(REG_INNER_OUTPUT_LIMIT); i++) begin
            idx = CFG_ADDR_W'(i);
            if (idx == REG_OUTER_OUTPUT_LIMIT || idx == REG_INNER_OUTPUT_LIMIT)
                cfg_write(idx, pick_limit());
            else
                cfg_write(idx, pick_gain());
        end
        if ($urandom_range(0, 2) == 0)
            cfg_write(REG_INNER_OUTPUT_LIMIT + CFG_ADDR_W'($urandom_range(1, 8)),
                      CFG_DATA_W'($urandom()));
        cfg_we <= 1'b0;
    endtask

    // mostly tracking samples near the setpoint, some full-range noise
    task automatic random_sample();
        int span;
        int tgt;
        if ($urandom_range(0, 9) < 3) begin
            send_sample(sample_t'($urandom()), sample_t'($urandom()), sample_t'($urandom()));
        end else begin
            case ($urandom_range(0, 2))
                0:       span = 64;
                1:       span = 1024;
                default: span = 16384;
            endcase
            tgt = int'($urandom_range(0, 2 * span)) - span;
            send_sample(sample_t'(tgt + int'($urandom_range(0, span / 4)) - span / 8),
                        sample_t'(tgt),
                        sample_t'(int'($urandom_range(0, 2 * span)) - span));
        end
    endtask

    // main sequence
    initial begin
        model     = new();
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        gap_pct   = 0;
        stall_pct = 0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: field extremes and unit steps
        gap_pct   = 20;
        stall_pct = 20;
        send_sample(16'sd0, 16'sd0, 16'sd0);
        send_sample(-16'sd32768, 16'sd32767, 16'sd0);
        send_sample(16'sd32767, -16'sd32768, 16'sd32767);
        send_sample(16'sd0, 16'sd1, 16'sd0);
        send_sample(16'sd1, 16'sd0, -16'sd1);
        send_sample(16'sd32767, 16'sd32767, -16'sd32768);
        wait_drained();

        // extreme gains: integrals run into their bounds both ways
        cfg_write(REG_OUTER_PROP_GAIN, 16'h7FFF);
        cfg_write(REG_OUTER_INT_GAIN, 16'h7FFF);
        cfg_write(REG_OUTER_DIFF_GAIN, 16'h7FFF);
        cfg_write(REG_OUTER_OUTPUT_LIMIT, 16'h7FFF);
        cfg_write(REG_INNER_PROP_GAIN, 16'h8000);
        cfg_write(REG_INNER_INT_GAIN, 16'h8000);
        cfg_write(REG_INNER_DIFF_GAIN, 16'h8000);
        cfg_write(REG_INNER_OUTPUT_LIMIT, 16'h7FFF);
        cfg_we <= 1'b0;
        repeat (4) send_sample(-16'sd32768, 16'sd32767, 16'sd32767);
        repeat (4) send_sample(16'sd32767, -16'sd32768, -16'sd32768);
        send_sample(16'sd0, 16'sd0, 16'sd0);
        wait_drained();

        // zero outer limit, bits above the limit width, ignored index, half rounding
        cfg_write(REG_OUTER_PROP_GAIN, 16'h0100);
        cfg_write(REG_OUTER_INT_GAIN, 16'h0001);
        cfg_write(REG_OUTER_DIFF_GAIN, 16'h0000);
        cfg_write(REG_OUTER_OUTPUT_LIMIT, 16'h0000);
        cfg_write(REG_INNER_PROP_GAIN, 16'h0080);
        cfg_write(REG_INNER_INT_GAIN, 16'h0001);
        cfg_write(REG_INNER_DIFF_GAIN, 16'h0000);
        cfg_write(REG_INNER_OUTPUT_LIMIT, 16'hFFFF);
        cfg_write(REG_INNER_OUTPUT_LIMIT + CFG_ADDR_W'(1), 16'h0000);
        cfg_write(REG_INNER_OUTPUT_LIMIT + CFG_ADDR_W'(8), 16'h1234);
        cfg_we <= 1'b0;
        send_sample(16'sd500, -16'sd700, 16'sd1);
        send_sample(-16'sd500, 16'sd700, -16'sd1);
        send_sample(16'sd0, 16'sd0, 16'sd3);
        send_sample(16'sd0, 16'sd0, -16'sd3);
        send_sample(16'sd0, 16'sd0, 16'sd5);
        wait_drained();

        // random phases, the last one with no idling on either side
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            random_config();
            if (ph == RAND_PHASES - 1) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : 10 * $urandom_range(1, 4);
                stall_pct = ($urandom_range(0, 2) == 0) ? 0 : 10 * $urandom_range(1, 4);
            end
            repeat (ITEMS_PER_PHASE) random_sample();
            wait_drained();
        end

        // let any stray result show up before the verdict
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (model.errors == 0 && model.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // watchdog
    initial begin
        #25_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
